FILE: src/tpi_pkg.sv
// Shared widths, types and helpers for the three-plane intersection core.
`timescale 1ns / 1ps
package tpi_pkg;

  localparam int NW   = 16;        // normal component, Q2.14
  localparam int OW   = 32;        // offset, Q16.16
  localparam int PW   = 2 * NW;    // normal by normal product
  localparam int CW   = PW + 1;    // cross product component
  localparam int DTW  = NW + CW;   // determinant term
  localparam int DW   = DTW + 2;   // determinant, sum of three terms
  localparam int NTW  = OW + CW;   // numerator term
  localparam int NUMW = NTW + 2;   // numerator, sum of three terms
  localparam int QS   = 14;        // fraction shift applied to the numerator
  localparam int QW   = 32;        // quotient bits produced by the divider
  localparam int HIW  = NUMW - (QW - QS); // dividend bits above the quotient window
  localparam int EW   = 32;        // epsilon register

  localparam logic [EW-1:0] DET_EPS_RESET = EW'(4096);

  localparam logic [QW-1:0] POS_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_MIN = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic neg;   // quotient sign
    logic ovf;   // quotient already known to exceed the window
  } lane_ctl_t;

  typedef struct packed {
    logic [QW-1:0] val;
    logic          sat;
  } coord_t;

  function automatic coord_t clip_coord(input logic [QW-1:0] q, input lane_ctl_t ctl);
    coord_t res;
    res.sat = 1'b0;
    if (ctl.neg) begin
      if (ctl.ovf || (q > NEG_MIN)) begin
        res.val = NEG_MIN;
        res.sat = 1'b1;
      end else begin
        res.val = QW'(0) - q;
      end
    end else begin
      if (ctl.ovf || (q > POS_MAX)) begin
        res.val = POS_MAX;
        res.sat = 1'b1;
      end else begin
        res.val = q;
      end
    end
    return res;
  endfunction

endpackage

FILE: src/three_plane_intersection_core.sv
// Top level: three-plane intersection by Cramer's rule, fully pipelined.
`timescale 1ns / 1ps
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+--------------------------------------
//  in_     | input     | in_valid / in_ready | three normals (Q2.14), three offsets
//  out_    | output    | out_valid/out_ready | point x/y/z (Q16.16), found, saturated
//  cfg_    | input     | cfg_wr_en           | det_epsilon, 32 bit, 2^-42 units
//
//  One word enters per cycle unless out_ready stalls the pipeline; each word passes
//  through 40 registers (7 arithmetic stages, 32 divider stages, one output register,
//  the first loaded on the accepting edge).
//  The 32-stage quotient pipeline sets the latency; the rate is one word a cycle.
//  Reset (rst_n low, synchronous) clears every valid bit, holds in_ready low and
//  loads det_epsilon with 4096. A stall on out_ready freezes the whole pipeline,
//  in_ready with it.
//
module three_plane_intersection_core import tpi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [NW-1:0] in_first_normal_x,
  input  logic signed [NW-1:0] in_first_normal_y,
  input  logic signed [NW-1:0] in_first_normal_z,
  input  logic signed [OW-1:0] in_first_offset,
  input  logic signed [NW-1:0] in_second_normal_x,
  input  logic signed [NW-1:0] in_second_normal_y,
  input  logic signed [NW-1:0] in_second_normal_z,
  input  logic signed [OW-1:0] in_second_offset,
  input  logic signed [NW-1:0] in_third_normal_x,
  input  logic signed [NW-1:0] in_third_normal_y,
  input  logic signed [NW-1:0] in_third_normal_z,
  input  logic signed [OW-1:0] in_third_offset,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [QW-1:0] out_point_x,
  output logic signed [QW-1:0] out_point_y,
  output logic signed [QW-1:0] out_point_z,
  output logic                 out_found,
  output logic                 out_saturated,
  input  logic                 cfg_wr_en,
  input  logic [EW-1:0]        cfg_wr_data
);

  localparam int NSTG = 6; // stages A..F ahead of the divider launch stage G

  logic en;
  logic [EW-1:0] eps_r;

  // valid bits of stages A..F, G, divider, output
  logic [NSTG-1:0] vld_r;
  logic            g_vld_r;
  logic [QW-1:0]   dv_vld_r;
  logic [QW-1:0]   dv_fnd_r;
  logic            out_valid_r;

  // the whole pipeline advances unless a finished word is held at the output
  assign en       = ~out_valid_r | out_ready;
  assign in_ready = rst_n & en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= DET_EPS_RESET;
    end else if (cfg_wr_en) begin
      eps_r <= cfg_wr_data;
    end
  end

  // ---------------- stage A: capture the word ----------------
  logic signed [NW-1:0] a_n_r   [3][3];
  logic signed [OW-1:0] a_off_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      a_n_r[0][0] <= in_first_normal_x;
      a_n_r[0][1] <= in_first_normal_y;
      a_n_r[0][2] <= in_first_normal_z;
      a_n_r[1][0] <= in_second_normal_x;
      a_n_r[1][1] <= in_second_normal_y;
      a_n_r[1][2] <= in_second_normal_z;
      a_n_r[2][0] <= in_third_normal_x;
      a_n_r[2][1] <= in_third_normal_y;
      a_n_r[2][2] <= in_third_normal_z;
      a_off_r[0]  <= in_first_offset;
      a_off_r[1]  <= in_second_offset;
      a_off_r[2]  <= in_third_offset;
    end
  end

  // ---------------- stage B: cross-product partial products ----------------
  // row r of the cofactor matrix is n[r+1] x n[r+2]
  logic signed [PW-1:0] b_pa_r  [3][3];
  logic signed [PW-1:0] b_pb_r  [3][3];
  logic signed [NW-1:0] b_n0_r  [3];
  logic signed [OW-1:0] b_off_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          b_pa_r[r][k] <= a_n_r[(r+1)%3][(k+1)%3] * a_n_r[(r+2)%3][(k+2)%3];
          b_pb_r[r][k] <= a_n_r[(r+1)%3][(k+2)%3] * a_n_r[(r+2)%3][(k+1)%3];
        end
        b_n0_r[r]  <= a_n_r[0][r];
        b_off_r[r] <= a_off_r[r];
      end
    end
  end

  // ---------------- stage C: cofactors ----------------
  logic signed [CW-1:0] c_c_r   [3][3];
  logic signed [NW-1:0] c_n0_r  [3];
  logic signed [OW-1:0] c_off_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          c_c_r[r][k] <= CW'(b_pa_r[r][k]) - CW'(b_pb_r[r][k]);
        end
        c_n0_r[r]  <= b_n0_r[r];
        c_off_r[r] <= b_off_r[r];
      end
    end
  end

  // ---------------- stage D: determinant and numerator terms ----------------
  logic signed [DTW-1:0] d_dt_r [3];
  logic signed [NTW-1:0] d_nt_r [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d_dt_r[k] <= c_n0_r[k] * c_c_r[0][k];
        for (int r = 0; r < 3; r++) begin
          d_nt_r[r][k] <= c_off_r[r] * c_c_r[r][k];
        end
      end
    end
  end

  // ---------------- stage E: sums; numerators take the negated offsets ----------------
  logic signed [DW-1:0]   e_det_r;
  logic signed [NUMW-1:0] e_num_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      e_det_r <= DW'(d_dt_r[0]) + DW'(d_dt_r[1]) + DW'(d_dt_r[2]);
      for (int k = 0; k < 3; k++) begin
        e_num_r[k] <= NUMW'(0) - NUMW'(d_nt_r[0][k]) - NUMW'(d_nt_r[1][k])
                      - NUMW'(d_nt_r[2][k]);
      end
    end
  end

  // ---------------- stage F: magnitudes and signs ----------------
  logic [DW-1:0]   f_dmag_r;
  logic            f_dneg_r;
  logic [NUMW-1:0] f_nmag_r [3];
  logic            f_qneg_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      f_dneg_r <= e_det_r[DW-1];
      f_dmag_r <= e_det_r[DW-1] ? DW'(-e_det_r) : DW'(e_det_r);
      for (int k = 0; k < 3; k++) begin
        f_nmag_r[k] <= e_num_r[k][NUMW-1] ? NUMW'(-e_num_r[k]) : NUMW'(e_num_r[k]);
        f_qneg_r[k] <= e_num_r[k][NUMW-1] ^ e_det_r[DW-1];
      end
    end
  end

  // ---------------- stage G: tolerance test, overflow test, divider launch ----------------
  // the dividend is nmag * 2^14; the quotient window is its low 32 bits,
  // and a high part not below dmag means the quotient does not fit
  logic [DW-1:0] g_dmag_r;
  logic          g_fnd_r;
  logic [DW-1:0] g_hi_r  [3];
  logic [QW-1:0] g_lo_r  [3];
  lane_ctl_t     g_ctl_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      g_dmag_r <= f_dmag_r;
      g_fnd_r  <= f_dmag_r > DW'(eps_r);
      for (int k = 0; k < 3; k++) begin
        g_hi_r[k]      <= DW'(f_nmag_r[k][NUMW-1:QW-QS]);
        g_lo_r[k]      <= {f_nmag_r[k][QW-QS-1:0], {QS{1'b0}}};
        g_ctl_r[k].neg <= f_qneg_r[k];
        g_ctl_r[k].ovf <= DW'(f_nmag_r[k][NUMW-1:QW-QS]) >= f_dmag_r;
      end
    end
  end

  // ---------------- divider lanes ----------------
  logic [QW-1:0] quot    [3];
  lane_ctl_t     qctl    [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    tpi_div_lane u_div (
      .clk     (clk),
      .en      (en),
      .dmag    (g_dmag_r),
      .rem_in  (g_hi_r[k]),
      .low_in  (g_lo_r[k]),
      .ctl_in  (g_ctl_r[k]),
      .quot    (quot[k]),
      .ctl_out (qctl[k])
    );
  end

  // found travels beside the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      dv_fnd_r <= {dv_fnd_r[QW-2:0], g_fnd_r};
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      g_vld_r     <= 1'b0;
      dv_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NSTG-2:0], in_valid};
      g_vld_r     <= vld_r[NSTG-1];
      dv_vld_r    <= {dv_vld_r[QW-2:0], g_vld_r};
      out_valid_r <= dv_vld_r[QW-1];
    end
  end

  // ---------------- output register ----------------
  coord_t cx, cy, cz;
  logic   fnd;

  assign cx  = clip_coord(quot[0], qctl[0]);
  assign cy  = clip_coord(quot[1], qctl[1]);
  assign cz  = clip_coord(quot[2], qctl[2]);
  assign fnd = dv_fnd_r[QW-1];

  logic [QW-1:0] px_r, py_r, pz_r;
  logic          fnd_r, sat_r;

  // drop the point for degenerate planes
  always_ff @(posedge clk) begin
    if (en) begin
      px_r  <= fnd ? cx.val : '0;
      py_r  <= fnd ? cy.val : '0;
      pz_r  <= fnd ? cz.val : '0;
      fnd_r <= fnd;
      sat_r <= fnd & (cx.sat | cy.sat | cz.sat);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_point_x   = px_r;
  assign out_point_y   = py_r;
  assign out_point_z   = pz_r;
  assign out_found     = fnd_r;
  assign out_saturated = sat_r;

endmodule

FILE: src/tpi_div_lane.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module tpi_div_lane import tpi_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [DW-1:0]   dmag,
  input  logic [DW-1:0]   rem_in,
  input  logic [QW-1:0]   low_in,
  input  lane_ctl_t       ctl_in,
  output logic [QW-1:0]   quot,
  output lane_ctl_t       ctl_out
);

  logic [DW-1:0] rem_r  [QW];
  logic [DW-1:0] dmag_r [QW];
  logic [QW-1:0] low_r  [QW];
  lane_ctl_t     ctl_r  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW-1:0] rem_src;
    logic [DW-1:0] dmag_src;
    logic [QW-1:0] low_src;
    lane_ctl_t     ctl_src;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          qbit;
    logic [DW-1:0] rem_nxt;

    if (i == 0) begin : g_head
      assign rem_src  = rem_in;
      assign dmag_src = dmag;
      assign low_src  = low_in;
      assign ctl_src  = ctl_in;
    end else begin : g_body
      assign rem_src  = rem_r[i-1];
      assign dmag_src = dmag_r[i-1];
      assign low_src  = low_r[i-1];
      assign ctl_src  = ctl_r[i-1];
    end

    // shift in the next dividend bit, subtract if it fits
    assign trial   = {rem_src, low_src[QW-1]};
    assign diff    = trial - {1'b0, dmag_src};
    assign qbit    = ~diff[DW];
    assign rem_nxt = qbit ? diff[DW-1:0] : trial[DW-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        dmag_r[i] <= dmag_src;
        low_r[i]  <= {low_src[QW-2:0], qbit};
        ctl_r[i]  <= ctl_src;
      end
    end
  end

  assign quot    = low_r[QW-1];
  assign ctl_out = ctl_r[QW-1];

endmodule

FILE: bench/tpi_checker.sv
// Checker for the three-plane intersection core: predicts each result and compares it.
`timescale 1ns / 1ps
module tpi_checker import tpi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [NW-1:0] in_first_normal_x,
  input  logic signed [NW-1:0] in_first_normal_y,
  input  logic signed [NW-1:0] in_first_normal_z,
  input  logic signed [OW-1:0] in_first_offset,
  input  logic signed [NW-1:0] in_second_normal_x,
  input  logic signed [NW-1:0] in_second_normal_y,
  input  logic signed [NW-1:0] in_second_normal_z,
  input  logic signed [OW-1:0] in_second_offset,
  input  logic signed [NW-1:0] in_third_normal_x,
  input  logic signed [NW-1:0] in_third_normal_y,
  input  logic signed [NW-1:0] in_third_normal_z,
  input  logic signed [OW-1:0] in_third_offset,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [QW-1:0] out_point_x,
  input  logic signed [QW-1:0] out_point_y,
  input  logic signed [QW-1:0] out_point_z,
  input  logic                 out_found,
  input  logic                 out_saturated,
  input  logic                 cfg_wr_en,
  input  logic [EW-1:0]        cfg_wr_data,
  output int                   fail_count,
  output int                   words_taken,
  output int                   points_owed
);

  typedef struct packed {
    logic [QW-1:0] x;
    logic [QW-1:0] y;
    logic [QW-1:0] z;
    logic          found;
    logic          sat;
  } point_t;

  point_t        owed_points[$];
  logic [EW-1:0] eps;

  function automatic point_t intersect_planes(
    input logic signed [NW-1:0] ax, ay, az, input logic signed [OW-1:0] ao,
    input logic signed [NW-1:0] bx, by, bz, input logic signed [OW-1:0] bo,
    input logic signed [NW-1:0] cx, cy, cz, input logic signed [OW-1:0] co,
    input logic [EW-1:0] tol);
    logic signed [127:0] n[0:2][0:2];
    logic signed [127:0] cr[0:2][0:2];
    logic signed [127:0] ofs[0:2];
    logic signed [127:0] det, num;
    logic [127:0]        dmag, nmag, q;
    logic [QW-1:0]       val[0:2];
    logic                sat;
    point_t              res;
    n[0][0] = ax; n[0][1] = ay; n[0][2] = az; ofs[0] = ao;
    n[1][0] = bx; n[1][1] = by; n[1][2] = bz; ofs[1] = bo;
    n[2][0] = cx; n[2][1] = cy; n[2][2] = cz; ofs[2] = co;
    // row r of the cofactors is the cross product of the two other normals
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++)
        cr[r][k] = n[(r+1)%3][(k+1)%3] * n[(r+2)%3][(k+2)%3]
                 - n[(r+1)%3][(k+2)%3] * n[(r+2)%3][(k+1)%3];
    det = n[0][0] * cr[0][0] + n[0][1] * cr[0][1] + n[0][2] * cr[0][2];
    dmag = det < 0 ? -det : det;
    res = '0;
    if (dmag <= {96'd0, tol}) return res;
    sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      num = -(ofs[0] * cr[0][k] + ofs[1] * cr[1][k] + ofs[2] * cr[2][k]);
      nmag = num < 0 ? -num : num;
      q = (nmag << QS) / dmag;
      if ((num < 0) != (det < 0)) begin
        if (q > 128'h8000_0000) begin
          val[k] = NEG_MIN; sat = 1'b1;
        end else begin
          val[k] = QW'(0) - q[QW-1:0];
        end
      end else begin
        if (q > 128'h7FFF_FFFF) begin
          val[k] = POS_MAX; sat = 1'b1;
        end else begin
          val[k] = q[QW-1:0];
        end
      end
    end
    res.x = val[0]; res.y = val[1]; res.z = val[2];
    res.found = 1'b1;
    res.sat = sat;
    return res;
  endfunction

  always @(posedge clk) begin
    point_t want;
    int     errs;
    errs = 0;
    if (!rst_n) begin
      eps         <= DET_EPS_RESET;
      fail_count  <= 0;
      words_taken <= 0;
      points_owed <= 0;
    end else begin
      if (cfg_wr_en) eps <= cfg_wr_data;
      if (in_valid && in_ready) begin
        owed_points.insert(owed_points.size(), intersect_planes(
          in_first_normal_x, in_first_normal_y, in_first_normal_z, in_first_offset,
          in_second_normal_x, in_second_normal_y, in_second_normal_z, in_second_offset,
          in_third_normal_x, in_third_normal_y, in_third_normal_z, in_third_offset, eps));
        words_taken <= words_taken + 1;
      end
      if (out_valid && out_ready) begin
        if (owed_points.size() == 0) begin
          $error("result word with nothing expected");
          errs++;
        end else begin
          want = owed_points.pop_front();
          if (want.x !== out_point_x) begin
            $error("point_x: expected %h, got %h", want.x, out_point_x);
            errs++;
          end
          if (want.y !== out_point_y) begin
            $error("point_y: expected %h, got %h", want.y, out_point_y);
            errs++;
          end
          if (want.z !== out_point_z) begin
            $error("point_z: expected %h, got %h", want.z, out_point_z);
            errs++;
          end
          if (want.found !== out_found) begin
            $error("found: expected %b, got %b", want.found, out_found);
            errs++;
          end
          if (want.sat !== out_saturated) begin
            $error("saturated: expected %b, got %b", want.sat, out_saturated);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      points_owed <= owed_points.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
// Testbench top: stimulus, receiver stalls, configuration phases and the verdict.
`timescale 1ns / 1ps
module tb_top;
  import tpi_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [NW-1:0] nrm[0:8];   // first, second, third plane: x, y, z each
  logic signed [OW-1:0] ofs[0:2];
  logic                 out_valid;
  logic                 out_ready;
  logic signed [QW-1:0] out_point_x, out_point_y, out_point_z;
  logic                 out_found, out_saturated;
  logic                 cfg_wr_en;
  logic [EW-1:0]        cfg_wr_data;

  int fail_count, words_taken, points_owed;
  int hold_reqs, holds_done;

  three_plane_intersection_core dut (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_first_normal_x (nrm[0]), .in_first_normal_y (nrm[1]),
    .in_first_normal_z (nrm[2]), .in_first_offset (ofs[0]),
    .in_second_normal_x(nrm[3]), .in_second_normal_y(nrm[4]),
    .in_second_normal_z(nrm[5]), .in_second_offset(ofs[1]),
    .in_third_normal_x (nrm[6]), .in_third_normal_y (nrm[7]),
    .in_third_normal_z (nrm[8]), .in_third_offset (ofs[2]),
    .out_valid, .out_ready, .out_point_x, .out_point_y, .out_point_z,
    .out_found, .out_saturated, .cfg_wr_en, .cfg_wr_data
  );

  tpi_checker chk (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_first_normal_x (nrm[0]), .in_first_normal_y (nrm[1]),
    .in_first_normal_z (nrm[2]), .in_first_offset (ofs[0]),
    .in_second_normal_x(nrm[3]), .in_second_normal_y(nrm[4]),
    .in_second_normal_z(nrm[5]), .in_second_offset(ofs[1]),
    .in_third_normal_x (nrm[6]), .in_third_normal_y (nrm[7]),
    .in_third_normal_z (nrm[8]), .in_third_offset (ofs[2]),
    .out_valid, .out_ready, .out_point_x, .out_point_y, .out_point_z,
    .out_found, .out_saturated, .cfg_wr_en, .cfg_wr_data,
    .fail_count, .words_taken, .points_owed
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Generous ceiling on the run time.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: change stall pattern at random intervals; on request hold off
  // for a long stretch so the pipeline fills and in_ready drops.
  initial begin
    int mode, mode_left, hold_left, cyc;
    logic rdy;
    mode_left = 0; hold_left = 0; cyc = 0; mode = 0;
    out_ready = 1'b0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_left == 0 && hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        hold_left = 300;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      case (mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = cyc[2];
      endcase
      if (hold_left > 0) begin
        rdy = 1'b0;
        hold_left--;
      end
      out_ready <= rdy;
    end
  end

  // Offer the word held in nrm/ofs; return at the falling edge after it is taken.
  task automatic offer_word();
    int seen;
    seen = words_taken;
    in_valid <= 1'b1;
    do @(negedge clk); while (words_taken == seen);
  endtask

  task automatic load_planes(input logic [NW-1:0] ax, ay, az, input logic [OW-1:0] ao,
                             input logic [NW-1:0] bx, by, bz, input logic [OW-1:0] bo,
                             input logic [NW-1:0] cx, cy, cz, input logic [OW-1:0] co);
    nrm[0] <= ax; nrm[1] <= ay; nrm[2] <= az; ofs[0] <= ao;
    nrm[3] <= bx; nrm[4] <= by; nrm[5] <= bz; ofs[1] <= bo;
    nrm[6] <= cx; nrm[7] <= cy; nrm[8] <= cz; ofs[2] <= co;
  endtask

  // Random plane triple; the flavour picks how likely a point, a clip or a
  // degenerate result is.
  task automatic load_random_planes();
    logic [NW-1:0] v[0:8];
    logic [OW-1:0] o[0:2];
    int flavour;
    flavour = $urandom_range(0, 5);
    for (int i = 0; i < 9; i++) begin
      case (flavour)
        0, 1: v[i] = NW'($urandom);
        2:    v[i] = NW'($signed($urandom_range(0, 32768)) - 16384);
        3:    v[i] = NW'($signed($urandom_range(0, 128)) - 64);
        default: v[i] = NW'($signed($urandom_range(0, 8192)) - 4096);
      endcase
    end
    for (int i = 0; i < 3; i++)
      o[i] = (flavour == 2) ? OW'($signed($urandom_range(0, 1 << 25)) - (1 << 24))
                            : OW'($urandom);
    // near-degenerate: third normal a small nudge from the first
    if (flavour == 4)
      for (int k = 0; k < 3; k++)
        v[6+k] = v[k] + NW'($signed($urandom_range(0, 6)) - 3);
    // exactly parallel, on a random half of these draws: third normal copies the second
    if (flavour == 5 && $urandom_range(0, 1))
      for (int k = 0; k < 3; k++) v[6+k] = v[3+k];
    load_planes(v[0], v[1], v[2], o[0], v[3], v[4], v[5], o[1], v[6], v[7], v[8], o[2]);
  endtask

  task automatic drain();
    while (points_owed != 0 || chk.owed_points.size() != 0) @(negedge clk);
  endtask

  task automatic write_eps(input logic [EW-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random burst traffic; a gap of zero keeps valid high across words.
  task automatic random_traffic(input int count);
    int burst_left, gap;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
      load_random_planes();
      offer_word();
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    logic [EW-1:0] eps_plan[0:4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    hold_reqs = 0;
    for (int i = 0; i < 9; i++) nrm[i] = '0;
    for (int i = 0; i < 3; i++) ofs[i] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words under the reset tolerance.
    // all-zero normals: determinant zero, nothing found
    load_planes(16'd0, 16'd0, 16'd0, 0, 16'd0, 16'd0, 16'd0, 0,
                16'd0, 16'd0, 16'd0, 0); offer_word();
    // unit axes: the point is the negated offsets, clipping at the high extreme
    load_planes(16'd16384, 16'd0, 16'd0, 32'h8000_0000, 16'd0, 16'd16384, 16'd0,
                32'h7FFF_FFFF, 16'd0, 16'd0, 16'd16384, 32'h0001_0000); offer_word();
    load_planes(16'd16384, 16'd0, 16'd0, 32'h8000_0001, 16'd0, 16'd16384, 16'd0,
                32'hFFFF_FFFF, 16'd0, 16'd0, 16'd16384, 0); offer_word();
    // negated axes: negative determinant
    load_planes(16'h8000, 16'd0, 16'd0, 32'h7FFF_FFFF, 16'd0, 16'h8000, 16'd0,
                32'h8000_0000, 16'd0, 16'd0, 16'h8000, 32'h1234_5678); offer_word();
    // every normal at the most negative code: parallel planes
    load_planes(16'h8000, 16'h8000, 16'h8000, 32'h7FFF_FFFF,
                16'h8000, 16'h8000, 16'h8000, 32'h8000_0000,
                16'h8000, 16'h8000, 16'h8000, 32'hFFFF_FFFF); offer_word();
    // mixed extremes, full-scale determinant
    load_planes(16'h7FFF, 16'h8000, 16'd0, 32'h7FFF_FFFF,
                16'h7FFF, 16'h7FFF, 16'h8000, 32'h8000_0000,
                16'h8000, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF); offer_word();
    // tiny normals: determinant 1, well inside the tolerance
    load_planes(16'd1, 16'd0, 16'd0, 32'h0001_0000, 16'd0, 16'd1, 16'd0, 0,
                16'd0, 16'd0, 16'd1, 0); offer_word();
    // determinant exactly at and just above the reset tolerance (16*16*16)
    load_planes(16'd16, 16'd0, 16'd0, 5, 16'd0, 16'd16, 16'd0, 6,
                16'd0, 16'd0, 16'd16, 7); offer_word();
    load_planes(16'd16, 16'd0, 16'd0, 5, 16'd0, 16'd16, 16'd0, 6,
                16'd0, 16'd0, 16'd17, 7); offer_word();
    // small determinant with large offsets: every coordinate clips
    load_planes(16'd64, 16'd0, 16'd0, 32'h7FFF_FFFF, 16'd0, 16'd64, 16'd0, 32'h8000_0000,
                16'd0, 16'd0, 16'd64, 32'h7FFF_FFFF); offer_word();
    // zero offsets through a general matrix: point at the origin
    load_planes(16'h1234, 16'hF00D, 16'h0456, 0, 16'h0FED, 16'h2345, 16'hCAFE, 0,
                16'h3000, 16'h0042, 16'h4000, 0); offer_word();
    in_valid <= 1'b0;
    drain();

    eps_plan[0] = DET_EPS_RESET;
    eps_plan[1] = '0;
    eps_plan[2] = '1;
    eps_plan[3] = $urandom;
    eps_plan[4] = 32'd4097;
    for (int ph = 0; ph < 5; ph++) begin
      // pipeline empty: leave it the full latency before touching the register
      repeat (45) @(negedge clk);
      write_eps(eps_plan[ph]);
      if (ph == 1) begin
        // zero tolerance: only an exactly zero determinant is degenerate
        load_planes(16'd16, 16'd0, 16'd0, 5, 16'd0, 16'd16, 16'd0, 6,
                    16'd0, 16'd0, 16'd16, 7); offer_word();
        load_planes(16'd1, 16'd0, 16'd0, 32'h7FFF_FFFF, 16'd0, 16'd1, 16'd0, 1,
                    16'd0, 16'd0, 16'd1, 32'h8000_0000);
        offer_word();
        in_valid <= 1'b0;
      end
      if (ph == 2) hold_reqs++;  // long receiver hold-off while words keep coming
      random_traffic(ph == 2 ? 90 : 110);
      // pause until every result has come back
      drain();
    end

    repeat (60) @(negedge clk);
    if (fail_count == 0 && chk.owed_points.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
